### hdl/anbx_pkg.sv
`default_nettype none

package anbx_pkg;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_CODEC_MODE    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_ENABLE = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_TYPE   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_ONLY    = 4'd3;

  localparam logic [5:0] FILTER_TYPE_RESET = 6'd7;

  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_END = 1'b1;

  localparam logic CODEC_H264 = 1'b0;
  localparam logic CODEC_H265 = 1'b1;

  // Results caused by one input word: zero run, data byte, end marker.
  localparam int unsigned GROUP_SLOTS = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [15:0] repeat_count;
    logic        unit_first;
    logic [5:0]  unit_type;
    logic [1:0]  ref_level;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [GROUP_SLOTS-1:0]            valid;
    out_item_t [GROUP_SLOTS-1:0]       item;
  } res_group_t;

endpackage

`default_nettype wire

### hdl/annexb_nal_deframer.sv
// Annex-B NAL deframer: parses an H.264 or H.265 byte stream, one byte per
// input word, into tagged payload runs and end-of-unit markers.
// Input channel in_valid/in_ready/in_data carries one stream byte and a
// stream-end flag. Output channel out_valid/out_ready/out_data carries one
// result word: a payload run (byte and repeat count) or an end marker.
// Configuration writes use cfg_valid/cfg_index/cfg_data; cfg_ready is always
// high, and writes are expected only while the block is idle.
// The front stage classifies each byte combinationally and pushes the zero to
// three words it causes, as one group, into a QUEUE_DEPTH-deep queue. The
// back stage sends them out from a group register, one per cycle while
// out_ready is high. The first word of a byte passes the queue slot, then
// the group register. One byte per cycle is taken while each byte yields at
// most one word and out_ready is high; else the output port sets the rate.
// When the receiver stalls, the queue fills and in_ready drops when it is
// full; nothing is lost. Reset clears the parse state, the queue and the
// output, and sets the registers to H.264, no filter, filter type 7.
`default_nettype none

module annexb_nal_deframer #(
  parameter int unsigned ZERO_RUN_BITS = 16,
  parameter int unsigned QUEUE_DEPTH   = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire anbx_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output anbx_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [anbx_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [anbx_pkg::CFG_DATA_W-1:0]   cfg_data
);

  anbx_pkg::res_group_t group;
  anbx_pkg::res_group_t q_data;
  logic                 push;
  logic                 step;
  logic                 q_full;
  logic                 q_not_empty;
  logic                 q_pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign step      = in_valid && in_ready;

  anbx_front #(
    .ZERO_RUN_BITS (ZERO_RUN_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .in_item   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .group     (group),
    .push      (push)
  );

  anbx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (group),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  anbx_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // An end marker carries no byte, no count and no header flag.
  a_end_marker_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.item_kind == anbx_pkg::KIND_END) |->
      (out_data.payload_byte == 8'h00) && (out_data.repeat_count == 16'd0) &&
      !out_data.unit_first && out_data.last_of_run)
    else $error("end marker with payload fields set");

  // Every payload run covers at least one byte.
  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.item_kind == anbx_pkg::KIND_RUN) |->
      (out_data.repeat_count != 16'd0))
    else $error("payload run with zero count");

  // The queue never takes a group while full, since the front only pushes
  // on an accepted byte.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("group pushed into a full queue");

  // A byte that causes results while the back stage is idle reaches the
  // output through the queue and the group register.
  a_output_follows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !q_not_empty && !out_valid |=> ##1 out_valid)
    else $error("pushed group did not reach the output");

endmodule

`default_nettype wire

### hdl/anbx_front.sv
`default_nettype none

module anbx_front #(
  parameter int unsigned ZERO_RUN_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              step,
  input  wire anbx_pkg::in_item_t                in_item,
  input  wire logic                              cfg_we,
  input  wire logic [anbx_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [anbx_pkg::CFG_DATA_W-1:0]   cfg_data,
  output anbx_pkg::res_group_t                   group,
  output logic                                   push
);

  logic                     codec_mode_r;
  logic                     filter_enable_r;
  logic [5:0]               filter_type_r;
  logic                     first_only_r;

  logic                     in_unit_r, in_unit_nxt;
  logic [ZERO_RUN_BITS-1:0] zero_run_r, zero_run_nxt;
  logic                     header_seen_r, header_seen_nxt;
  logic                     unit_passed_r, unit_passed_nxt;
  logic                     match_done_r, match_done_nxt;
  logic [5:0]               held_type_r, held_type_nxt;
  logic [1:0]               held_ref_r, held_ref_nxt;

  logic [7:0]               b;
  logic                     last;
  logic [31:0]              zr_w;
  logic                     is_zero, is_sc, is_other;
  logic [ZERO_RUN_BITS-1:0] zr_inc;
  logic                     call_a, call_b, call_e;
  logic [ZERO_RUN_BITS-1:0] cnt_a;
  logic                     hs_a, ps_a, first_a;
  logic [5:0]               ty_a;
  logic [1:0]               rf_a;
  logic                     hs_b, ps_b, first_b;
  logic [5:0]               ty_b;
  logic [1:0]               rf_b;
  logic [5:0]               hdr_type_b;
  logic [1:0]               hdr_ref_b;
  logic                     v_a, v_b, v_e;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    logic [15:0] r;
    r = (v > 32'd65535) ? 16'hFFFF : v[15:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_mode_r    <= anbx_pkg::CODEC_H264;
      filter_enable_r <= 1'b0;
      filter_type_r   <= anbx_pkg::FILTER_TYPE_RESET;
      first_only_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        anbx_pkg::CFG_CODEC_MODE:    codec_mode_r    <= cfg_data[0];
        anbx_pkg::CFG_FILTER_ENABLE: filter_enable_r <= cfg_data[0];
        anbx_pkg::CFG_FILTER_TYPE:   filter_type_r   <= cfg_data[5:0];
        anbx_pkg::CFG_FIRST_ONLY:    first_only_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    b        = in_item.data_byte;
    last     = in_item.stream_end;
    zr_w     = 32'(zero_run_r);
    is_zero  = (b == 8'h00);
    is_sc    = (b == 8'h01) && (zr_w >= 32'd2);
    is_other = !is_zero && !is_sc;
    zr_inc   = (&zero_run_r) ? zero_run_r : zero_run_r + 1'b1;

    // The zero run is decided here: payload, part of the prefix, or trailing.
    if (is_zero) begin
      call_a = last && in_unit_r && (codec_mode_r == anbx_pkg::CODEC_H264);
      cnt_a  = zr_inc;
    end else if (is_sc) begin
      call_a = in_unit_r && (codec_mode_r == anbx_pkg::CODEC_H264) && (zr_w > 32'd3);
      cnt_a  = zero_run_r - ZERO_RUN_BITS'(3);
    end else begin
      call_a = in_unit_r && (zero_run_r != '0);
      cnt_a  = zero_run_r;
    end
    call_b = is_other && in_unit_r;
    call_e = in_unit_r && (is_sc || last);

    // A zero byte as header gives type 0 and ref_idc 0 in both modes.
    hs_a    = header_seen_r;
    ps_a    = unit_passed_r;
    ty_a    = held_type_r;
    rf_a    = held_ref_r;
    first_a = 1'b0;
    if (call_a && !header_seen_r) begin
      ty_a    = 6'd0;
      rf_a    = 2'd0;
      ps_a    = !match_done_r && (!filter_enable_r || (filter_type_r == 6'd0));
      hs_a    = 1'b1;
      first_a = 1'b1;
    end

    if (codec_mode_r == anbx_pkg::CODEC_H265) begin
      hdr_type_b = b[6:1];
      hdr_ref_b  = 2'd0;
    end else begin
      hdr_type_b = {1'b0, b[4:0]};
      hdr_ref_b  = b[6:5];
    end
    hs_b    = hs_a;
    ps_b    = ps_a;
    ty_b    = ty_a;
    rf_b    = rf_a;
    first_b = 1'b0;
    if (call_b && !hs_a) begin
      ty_b    = hdr_type_b;
      rf_b    = hdr_ref_b;
      ps_b    = !match_done_r && (!filter_enable_r || (filter_type_r == hdr_type_b));
      hs_b    = 1'b1;
      first_b = 1'b1;
    end

    v_a = call_a && ps_a;
    v_b = call_b && ps_b;
    v_e = call_e && hs_b && ps_b;

    group.valid = {v_e, v_b, v_a};

    group.item[0].item_kind    = anbx_pkg::KIND_RUN;
    group.item[0].payload_byte = 8'h00;
    group.item[0].repeat_count = sat16(32'(cnt_a));
    group.item[0].unit_first   = first_a;
    group.item[0].unit_type    = ty_a;
    group.item[0].ref_level    = rf_a;
    group.item[0].last_of_run  = !v_b && !v_e;

    group.item[1].item_kind    = anbx_pkg::KIND_RUN;
    group.item[1].payload_byte = b;
    group.item[1].repeat_count = 16'd1;
    group.item[1].unit_first   = first_b;
    group.item[1].unit_type    = ty_b;
    group.item[1].ref_level    = rf_b;
    group.item[1].last_of_run  = !v_e;

    group.item[2].item_kind    = anbx_pkg::KIND_END;
    group.item[2].payload_byte = 8'h00;
    group.item[2].repeat_count = 16'd0;
    group.item[2].unit_first   = 1'b0;
    group.item[2].unit_type    = ty_b;
    group.item[2].ref_level    = rf_b;
    group.item[2].last_of_run  = 1'b1;

    push = step && (v_a || v_b || v_e);

    in_unit_nxt     = last ? 1'b0 : (is_sc ? 1'b1 : in_unit_r);
    zero_run_nxt    = (!last && is_zero) ? zr_inc : '0;
    header_seen_nxt = (last || is_sc || call_e) ? 1'b0 : hs_b;
    unit_passed_nxt = (last || is_sc || call_e) ? 1'b0 : ps_b;
    match_done_nxt  = last ? 1'b0 : (match_done_r || (v_e && first_only_r));
    held_type_nxt   = last ? 6'd0 : ty_b;
    held_ref_nxt    = last ? 2'd0 : rf_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_unit_r     <= 1'b0;
      zero_run_r    <= '0;
      header_seen_r <= 1'b0;
      unit_passed_r <= 1'b0;
      match_done_r  <= 1'b0;
      held_type_r   <= 6'd0;
      held_ref_r    <= 2'd0;
    end else if (step) begin
      in_unit_r     <= in_unit_nxt;
      zero_run_r    <= zero_run_nxt;
      header_seen_r <= header_seen_nxt;
      unit_passed_r <= unit_passed_nxt;
      match_done_r  <= match_done_nxt;
      held_type_r   <= held_type_nxt;
      held_ref_r    <= held_ref_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/anbx_queue.sv
`default_nettype none

module anbx_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire anbx_pkg::res_group_t push_data,
  input  wire logic                 pop,
  output anbx_pkg::res_group_t      pop_data,
  output logic                      not_empty,
  output logic                      full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  anbx_pkg::res_group_t slots_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 do_push, do_pop;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_data  = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/anbx_back.sv
`default_nettype none

module anbx_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_not_empty,
  input  wire anbx_pkg::res_group_t q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output anbx_pkg::out_item_t       out_data
);

  logic [anbx_pkg::GROUP_SLOTS-1:0] mask_r, mask_nxt;
  anbx_pkg::out_item_t [anbx_pkg::GROUP_SLOTS-1:0] items_r;
  logic [anbx_pkg::GROUP_SLOTS-1:0] remain;
  logic                             taken;

  assign out_valid = (mask_r != '0);
  assign taken     = out_valid && out_ready;
  // Clear the lowest pending slot once its word is taken.
  assign remain    = taken ? (mask_r & (mask_r - 1'b1)) : mask_r;
  assign q_pop     = q_not_empty && (remain == '0);
  assign mask_nxt  = q_pop ? q_data.valid : remain;

  always_comb begin
    priority if (mask_r[0]) begin
      out_data = items_r[0];
    end else if (mask_r[1]) begin
      out_data = items_r[1];
    end else begin
      out_data = items_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      items_r <= q_data.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

endmodule

`default_nettype wire
